/* src/sliding_window_event_rate_defines.svh */
// Assertion helpers for the checker file (swer_chk).
`ifndef SLIDING_WINDOW_EVENT_RATE_DEFINES_SVH
`define SLIDING_WINDOW_EVENT_RATE_DEFINES_SVH

// Checked only while out of reset.
`define SWER_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SWER_CHK_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/swer_pkg.sv */
package swer_pkg;

	localparam int BUCKETS_DEF = 12;
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
	localparam logic [CNT_W-1:0] PERIOD_RST = 16'd5000;

	// stage 1 -> accumulator
	typedef struct packed {
		logic vld;
		logic roll;
		logic inc;
	} s1_t;

endpackage

/* src/swer_bucket_ram.sv */
module swer_bucket_ram
	import swer_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	localparam int HW = $clog2(BUCKETS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [HW-1:0]    wr_addr,
	input  logic [CNT_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [HW-1:0]    rd_addr,
	output logic [CNT_W-1:0] rd_data
);

	logic [CNT_W-1:0] mem [BUCKETS];
	logic [CNT_W-1:0] rd_mem_q;
	logic [BUCKETS-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q <= mem[rd_addr];
		end
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

/* src/swer_ctrl.sv */
module swer_ctrl
	import swer_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	localparam int HW = $clog2(BUCKETS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             adv,
	input  logic             tick,
	input  logic             event_req,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	output logic             wr_en,
	output logic [HW-1:0]    wr_addr,
	output logic [CNT_W-1:0] wr_data,
	output logic             rd_en,
	output logic [HW-1:0]    rd_addr,
	output s1_t              s1
);

	logic [CNT_W-1:0] period_q;
	logic [CNT_W-1:0] ms_q;
	logic [HW-1:0]    head_q;
	logic [CNT_W-1:0] hcnt_q;
	s1_t              s1_q;

	logic [CNT_W-1:0] period_eff;
	logic [CNT_W:0]   ms_nx;
	logic             roll;
	logic [HW-1:0]    head_nx;
	logic [CNT_W-1:0] cnt_base;
	logic             inc;

	always_comb begin
		period_eff = (period_q == '0) ? CNT_W'(1) : period_q;
		ms_nx = {1'b0, ms_q} + (CNT_W+1)'(1);
		roll = tick && (ms_nx >= {1'b0, period_eff});
		head_nx = (head_q == HW'(BUCKETS - 1)) ? '0 : head_q + HW'(1);
		cnt_base = roll ? '0 : hcnt_q;
		inc = event_req && (cnt_base != CNT_MAX);
	end

	// leaving bucket is written back, entered bucket is read for the total
	assign wr_en = accept && roll;
	assign wr_addr = head_q;
	assign wr_data = hcnt_q;
	assign rd_en = accept && roll;
	assign rd_addr = head_nx;
	assign s1 = s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			ms_q <= '0;
			head_q <= '0;
			hcnt_q <= '0;
			s1_q <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_data;
			end
			if (accept) begin
				if (tick) begin
					if (roll) begin
						ms_q <= '0;
						head_q <= head_nx;
					end else begin
						ms_q <= ms_nx[CNT_W-1:0];
					end
				end
				hcnt_q <= cnt_base + CNT_W'(inc);
				s1_q.vld <= 1'b1;
				s1_q.roll <= roll;
				s1_q.inc <= inc;
			end else if (adv) begin
				s1_q.vld <= 1'b0;
			end
		end
	end

endmodule

/* src/swer_accum.sv */
module swer_accum
	import swer_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	localparam int TW = CNT_W + $clog2(BUCKETS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  s1_t              s1,
	input  logic [CNT_W-1:0] rd_data,
	input  logic             out_ready,
	output logic             adv,
	output logic             out_valid,
	output logic [CNT_W-1:0] out_total,
	output logic             out_rolled
);

	logic [TW-1:0]    total_q;
	logic [TW-1:0]    total_nx;
	logic [CNT_W-1:0] sub;
	logic             out_vld_q;
	logic [CNT_W-1:0] out_total_q;
	logic             out_rolled_q;

	always_comb begin
		sub = s1.roll ? rd_data : '0;
		total_nx = total_q - TW'(sub) + TW'(s1.inc);
	end

	assign adv = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;
	assign out_total = out_total_q;
	assign out_rolled = out_rolled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv && s1.vld) begin
				total_q <= total_nx;
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1.vld) begin
			out_total_q <= (total_nx > TW'(CNT_MAX)) ? CNT_MAX : total_nx[CNT_W-1:0];
			out_rolled_q <= s1.roll;
		end
	end

endmodule

/* src/sliding_window_event_rate.sv */
// Throughput: one beat per cycle, sustained, while m_tready stays high.
// Two register stages: stage 1, then the output register, loaded when free or m_tready is high.
// The registered bucket RAM read on a ring advance sets the two-stage pipeline depth.
// Reset (arst_n low, asynchronous): counters, head and total clear, period returns to 5000,
// bucket entries read as zero until written again. No clearing pass.
module sliding_window_event_rate
	import swer_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	localparam int HW = $clog2(BUCKETS)
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tick, [1] event_req, [7:2] zero
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] window_total, [16] rolled, [23:17] zero
	// bucket_period_ms write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// Stage 1 (swer_ctrl): ms counter, head pointer and the head bucket's count
	// live in flops. Only the head bucket is ever modified, so on a ring advance the
	// old head's count is written back to RAM while the new head is read in the same
	// cycle. The two addresses always differ (at least two buckets), and an entry
	// written on one edge is readable on the next, so no forwarding is needed.
	// Stage 2 (swer_accum): the read count comes off the exact running total, the
	// event increment goes on, and the saturated total lands in the output register.

	logic             accept;
	logic             adv;
	s1_t              s1;
	logic             wr_en;
	logic [HW-1:0]    wr_addr;
	logic [CNT_W-1:0] wr_data;
	logic             rd_en;
	logic [HW-1:0]    rd_addr;
	logic [CNT_W-1:0] rd_data;
	logic [CNT_W-1:0] out_total;
	logic             out_rolled;

	// stage 1 may refill as soon as its beat moves on
	assign s_tready = !s1.vld || adv;
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tdata = {7'd0, out_rolled, out_total};

	swer_ctrl #(
		.BUCKETS(BUCKETS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.adv      (adv),
		.tick     (s_tdata[0]),
		.event_req(s_tdata[1]),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.s1       (s1)
	);

	swer_bucket_ram #(
		.BUCKETS(BUCKETS)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	swer_accum #(
		.BUCKETS(BUCKETS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.rd_data   (rd_data),
		.out_ready (m_tready),
		.adv       (adv),
		.out_valid (m_tvalid),
		.out_total (out_total),
		.out_rolled(out_rolled)
	);

endmodule

/* src/swer_chk.sv */
`include "sliding_window_event_rate_defines.svh"

module swer_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [15:0] cfg_data
);

	// a stalled result beat holds
	`SWER_CHK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// output register empty from the edge after reset is seen
	`SWER_CHK_ALL(a_rst_empty, !arst_n |=> !m_tvalid, "result beat shown in reset")

	// input only backs up when the output is full and stalled
	`SWER_CHK(a_bp_cause, !s_tready |-> m_tvalid && !m_tready, "input stalled without output backpressure")

	// an accepted beat goes from stage 1 into the output register when the sink is ready
	`SWER_CHK(a_latency, (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid, "result beat missing after accept")

endmodule

bind sliding_window_event_rate swer_chk u_chk (.*);

/* dv/sliding_window_event_rate_tb.sv */
`timescale 1ns / 1ps

// Rolling-window event counter: beats of {tick, event_req} go in and one result beat of
// {window_total, rolled} comes out per input. A scoreboard model of the bucket ring runs
// alongside the block and every result beat is compared against it in order.
module sliding_window_event_rate_tb
	import swer_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	// The result passes stage 1 and then the output register after the accepting edge; leave
	// a margin before touching the period.
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic        rolled;
		logic [15:0] window_total;
	} rate_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;       // [0] tick, [1] event_req, [7:2] zero
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [23:0] m_tdata;            // [15:0] window_total, [16] rolled, [23:17] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// Scoreboard copy of the ring and the period register.
	logic [CNT_W-1:0] win_bucket [BUCKETS_DEF];
	int unsigned      win_head;
	int unsigned      win_ms;
	int unsigned      win_sum;        // exact, never saturates
	logic [15:0]      win_period;

	rate_beat_t total_q[$];          // expected result beats, oldest first
	rate_beat_t want;
	int         mismatches = 0;
	int unsigned cyc = 0;

	// Idle control: random gaps on the input side, random stalls on the output side,
	// plus one long output hold-off to back the pipe up into s_tready.
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	bit rx_hold = 1'b0;
	int rx_hold_len = 0;
	int rx_stall = 0;

	sliding_window_event_rate uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("FAIL sliding_window_event_rate");
			$finish;
		end
	end

	// Advance the ring model by one input beat and return the result it should produce.
	// Tick first (may roll to the next bucket and drop its old count), then the event.
	function automatic rate_beat_t rate_step(input bit tick, input bit ev);
		rate_beat_t  r;
		int unsigned per;
		per = (win_period == 16'd0) ? 1 : win_period;   // zero period behaves as one
		r.rolled = 1'b0;
		if (tick) begin
			if (win_ms + 1 >= per) begin
				win_ms = 0;
				win_head = (win_head + 1) % BUCKETS_DEF;
				win_sum -= win_bucket[win_head];
				win_bucket[win_head] = '0;
				r.rolled = 1'b1;
			end else begin
				win_ms = win_ms + 1;
			end
		end
		// full bucket swallows the event, total untouched
		if (ev && win_bucket[win_head] != CNT_MAX) begin
			win_bucket[win_head] = win_bucket[win_head] + 1'b1;
			win_sum++;
		end
		r.window_total = (win_sum > CNT_MAX) ? CNT_MAX : win_sum[15:0];
		return r;
	endfunction

	// Output side: random stall bursts, or held low during a hold-off.
	always @(posedge clk) begin
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall = rx_stall - 1;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			rx_stall = $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Long hold-off, counted here so the sender keeps pushing in the meantime.
	initial forever begin
		@(posedge clk);
		if (rx_hold_len != 0) begin
			rx_hold = 1'b1;
			repeat (rx_hold_len) @(posedge clk);
			rx_hold = 1'b0;
			rx_hold_len = 0;
		end
	end

	// Result checker: each accepted beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (total_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: window_total %0d rolled %0d",
						m_tdata[15:0], m_tdata[16]);
			end else begin
				want = total_q.pop_front();
				if (m_tdata[15:0] !== want.window_total || m_tdata[16] !== want.rolled) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: window_total exp %0d got %0d, rolled exp %0d got %0d",
							want.window_total, m_tdata[15:0], want.rolled, m_tdata[16]);
				end
			end
		end
	end

	// One input beat, predicted at the accepting edge. Unless an idle gap drops it, valid
	// stays up on return so back-to-back beats need no re-assert in the same step.
	task automatic send_item(input bit tick, input bit ev);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, ev, tick};
		do @(posedge clk); while (!s_tready);
		total_q.push_back(rate_step(tick, ev));
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Period write, only with the pipe drained.
	task automatic write_period(input logic [15:0] val);
		s_tvalid <= 1'b0;
		while (total_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_period = val;
	endtask

	// All four flag combinations at the reset period, then period 1 (every tick rolls,
	// one full lap of the ring) and period 0, which must act as 1.
	task automatic test_directed();
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		write_period(16'd1);
		repeat (BUCKETS_DEF + 1) send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b1);
		write_period(16'd0);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b0);
	endtask

	// Period dropped to or below the elapsed ms: the next tick has to roll.
	task automatic test_period_lowered();
		write_period(16'd10);
		repeat (6) send_item(1'b1, 1'($urandom_range(0, 1)));
		write_period(16'd3);
		send_item(1'b1, 1'b0);
		repeat (4) send_item(1'b1, 1'b1);
		write_period(16'd4);
		repeat (3) send_item(1'b1, 1'b0);
		write_period(16'd2);
		send_item(1'b1, 1'b1);
	endtask

	// Output held off for a long stretch while input keeps coming: s_tready drops
	// and nothing may be lost or duplicated once the hold lifts.
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		write_period(16'd3);
		rx_hold_len = 300;
		repeat (80) send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// Random beats over a spread of periods, extremes included; tick density varies per
	// phase so some phases roll constantly and others almost never.
	task automatic test_random();
		logic [15:0] periods [7];
		int          tick_pct;
		int          ev_pct;
		periods = '{16'd1, 16'd0, 16'd2, 16'd13, PERIOD_RST, 16'hFFFF, 16'd3};
		periods[3] = 16'($urandom_range(3, 24));
		for (int ph = 0; ph < 7; ph++) begin
			// last phase runs flat out on both sides
			tx_idle_en = (ph != 6);
			rx_idle_en = (ph != 6);
			write_period(periods[ph]);
			tick_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(5, 90);
			ev_pct = $urandom_range(10, 95);
			repeat (225)
				send_item($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < ev_pct);
		end
	endtask

	initial begin
		for (int i = 0; i < BUCKETS_DEF; i++)
			win_bucket[i] = '0;
		win_head = 0;
		win_ms = 0;
		win_sum = 0;
		win_period = PERIOD_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_directed();
		test_period_lowered();
		test_backpressure();
		test_random();

		s_tvalid <= 1'b0;
		while (total_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && total_q.size() == 0) begin
			$display("PASS sliding_window_event_rate");
		end else begin
			$display("FAIL sliding_window_event_rate");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+src
src/swer_pkg.sv
src/swer_bucket_ram.sv
src/swer_ctrl.sv
src/swer_accum.sv
src/sliding_window_event_rate.sv
src/swer_chk.sv
dv/sliding_window_event_rate_tb.sv
